### sv/tarm_pkg.sv
// Shared types and constants for the thrust allocation rpm mapper.
`default_nettype none
package tarm_pkg;

	localparam int AXES   = 6;
	localparam int SAT_N  = 2 * AXES;
	localparam int VAL_W  = 32;
	localparam int RPM_W  = 16;
	localparam int MOD_W  = 8;
	localparam int MUL_W  = 34;
	localparam int ACC_W  = 2 * MUL_W;
	localparam int DF_W   = 33;
	localparam int Q_W    = 17;
	localparam int DSH_W  = DF_W + Q_W - 1;
	localparam int CNT_W  = $clog2(Q_W);

	// command codes of an input word
	typedef enum logic [2:0] {
		CMD_COMPUTE   = 3'd0,
		CMD_MATRIX    = 3'd1,
		CMD_THRUST_BP = 3'd2,
		CMD_RPM_BP    = 3'd3,
		CMD_MODIFIER  = 3'd4,
		CMD_SAT_LIMIT = 3'd5
	} cmd_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_ACTIVE = 2'd0,
		CFG_TCOUNT = 2'd1,
		CFG_BCOUNT = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DOT_RD,
		ST_DOT_MUL,
		ST_DOT_ACC,
		ST_LUT_RD0,
		ST_LUT_CHK0,
		ST_LUT_CHKN,
		ST_LUT_SRCH,
		ST_IP_M1,
		ST_IP_M2,
		ST_IP_ADD,
		ST_DIV,
		ST_DIV_END,
		ST_MOD_MUL,
		ST_MOD_SAT,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

### sv/tarm_tables.sv
// Table storage: allocation matrix, breakpoint tables, modifiers, saturation limits.
`default_nettype none
module tarm_tables
	import tarm_pkg::*;
#(
	parameter int MAX_THRUSTERS = 8,
	parameter int LUT_DEPTH     = 16,
	parameter int MAT_AW        = $clog2(MAX_THRUSTERS * AXES),
	parameter int BP_AW         = $clog2(LUT_DEPTH),
	parameter int TI_W          = (MAX_THRUSTERS > 1) ? $clog2(MAX_THRUSTERS) : 1
) (
	input  logic                    clk,
	input  logic                    ld_en,
	input  logic [2:0]              command,
	input  logic [3:0]              table_row,
	input  logic [2:0]              table_col,
	input  logic signed [VAL_W-1:0] table_value,
	input  logic [MAT_AW-1:0]       mat_addr,
	output logic signed [VAL_W-1:0] mat_rd,
	input  logic [BP_AW-1:0]        bp_addr,
	output logic signed [VAL_W-1:0] tbp_rd,
	output logic signed [RPM_W-1:0] rbp_rd,
	input  logic [TI_W-1:0]         mod_sel,
	output logic signed [MOD_W-1:0] mod_val,
	output logic signed [VAL_W-1:0] sat_lim [SAT_N]
);

	logic signed [VAL_W-1:0] mat_mem_q [MAX_THRUSTERS * AXES];
	logic signed [VAL_W-1:0] tbp_mem_q [LUT_DEPTH];
	logic signed [RPM_W-1:0] rbp_mem_q [LUT_DEPTH];
	logic signed [MOD_W-1:0] mod_q [MAX_THRUSTERS];
	logic signed [VAL_W-1:0] sat_q [SAT_N];

	logic [7:0] row8;
	logic [7:0] mat_wa8;
	logic       mat_ok, bp_ok, mod_ok, sat_ok;

	// load address decode; out of range loads are dropped
	assign row8    = 8'(table_row);
	assign mat_wa8 = row8 * 8'(AXES) + 8'(table_col);
	assign mat_ok  = (row8 < 8'(MAX_THRUSTERS)) && (8'(table_col) < 8'(AXES));
	assign bp_ok   = row8 < 8'(LUT_DEPTH);
	assign mod_ok  = row8 < 8'(MAX_THRUSTERS);
	assign sat_ok  = row8 < 8'(SAT_N);

	// writes
	always_ff @(posedge clk) begin
		if (ld_en) begin
			case (command)
				CMD_MATRIX: begin
					if (mat_ok) mat_mem_q[MAT_AW'(mat_wa8)] <= table_value;
				end
				CMD_THRUST_BP: begin
					if (bp_ok) tbp_mem_q[BP_AW'(table_row)] <= table_value;
				end
				CMD_RPM_BP: begin
					if (bp_ok) rbp_mem_q[BP_AW'(table_row)] <= table_value[RPM_W-1:0];
				end
				CMD_MODIFIER: begin
					if (mod_ok) mod_q[TI_W'(table_row)] <= table_value[MOD_W-1:0];
				end
				CMD_SAT_LIMIT: begin
					if (sat_ok) sat_q[table_row] <= table_value;
				end
				default: ;
			endcase
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		mat_rd <= mat_mem_q[mat_addr];
		tbp_rd <= tbp_mem_q[bp_addr];
		rbp_rd <= rbp_mem_q[bp_addr];
	end

	assign mod_val = mod_q[mod_sel];
	assign sat_lim = sat_q;

endmodule
`default_nettype wire

### sv/thrust_allocation_rpm_mapper_unit.sv
// Top level: sequencer and shared multiply/add/divide datapath of the rpm mapper.
//
//  channel   signals                                   direction  word
//  config    cfg_wr_en cfg_index cfg_data              in         register write, no wait
//  input     in_valid in_ready command .. table_value  in         compute or table load
//  output    out_valid out_ready thruster_index ..     out        one rpm per thruster
//
// A load word writes a table entry while the sequencer stays idle. While active, a compute
// word runs per thruster the dot product, breakpoint search, bit-serial divide, multiplies
// and output; while inactive it goes straight to output per thruster. The single shared
// 34x34 multiplier and the divide loop serialise that work. in_ready is high only in idle;
// a stalled output holds the sequencer. Reset clears sequencer, output valid and active
// flag, sets thruster and breakpoint counts to 8 and 16; tables need loading.
`default_nettype none
module thrust_allocation_rpm_mapper_unit
	import tarm_pkg::*;
#(
	parameter int MAX_THRUSTERS = 8,
	parameter int LUT_DEPTH     = 16,
	parameter int FRAC_BITS     = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [1:0]              cfg_index,
	input  logic [4:0]              cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              command,
	input  logic signed [VAL_W-1:0] force_x,
	input  logic signed [VAL_W-1:0] force_y,
	input  logic signed [VAL_W-1:0] force_z,
	input  logic signed [VAL_W-1:0] moment_x,
	input  logic signed [VAL_W-1:0] moment_y,
	input  logic signed [VAL_W-1:0] moment_z,
	input  logic [3:0]              table_row,
	input  logic [2:0]              table_col,
	input  logic signed [VAL_W-1:0] table_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              thruster_index,
	output logic signed [RPM_W-1:0] rpm_value,
	output logic                    last_thruster
);

	localparam int MAT_AW = $clog2(MAX_THRUSTERS * AXES);
	localparam int BP_AW  = $clog2(LUT_DEPTH);
	localparam int TI_W   = (MAX_THRUSTERS > 1) ? $clog2(MAX_THRUSTERS) : 1;
	localparam int THR_W  = ACC_W - FRAC_BITS;

	state_t state_q, state_d;

	logic       active_q;
	logic [3:0] tcount_q;
	logic [4:0] bcount_q;

	logic signed [VAL_W-1:0] in_vec [AXES];
	logic signed [VAL_W-1:0] vec_q [AXES];
	logic signed [VAL_W-1:0] sat_lim [SAT_N];
	logic signed [VAL_W-1:0] mat_rd, tbp_rd;
	logic signed [RPM_W-1:0] rbp_rd;
	logic signed [MOD_W-1:0] mod_val;

	logic [MAT_AW-1:0] mat_addr_q;
	logic [BP_AW-1:0]  bp_addr, i_q;
	logic [TI_W-1:0]   t_q;
	logic [2:0]        k_q;

	logic signed [ACC_W-1:0] acc_q, prod_q, sum_w, div_sub;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [THR_W-1:0] thr_q, tbp_ext, fd_full;
	logic signed [VAL_W-1:0] prev_bp_q, lo_bp_q;
	logic signed [RPM_W-1:0] prev_rpm_q, lo_rpm_q, lut_q, rpm_q;
	logic signed [DF_W-1:0]  df;
	logic signed [RPM_W:0]   dr;
	logic [DSH_W-1:0]        dsh_q;
	logic [Q_W-1:0]          q_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    neg_q;

	logic [4:0] tc_eff;
	logic [7:0] n_eff;
	logic [BP_AW-1:0] n_last;
	logic in_acc, ld_en, f_gt, f_lt, i_last, df_zero, dot_last, t_last, emit_go, div_ge;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			tcount_q <= 4'd8;
			bcount_q <= 5'd16;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ACTIVE: active_q <= cfg_data[0];
				CFG_TCOUNT: tcount_q <= cfg_data[3:0];
				CFG_BCOUNT: bcount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective counts
	always_comb begin
		if (tcount_q == 4'd0) tc_eff = 5'd1;
		else if (5'(tcount_q) > 5'(MAX_THRUSTERS)) tc_eff = 5'(MAX_THRUSTERS);
		else tc_eff = 5'(tcount_q);
		if (bcount_q < 5'd2) n_eff = 8'd2;
		else if (8'(bcount_q) > 8'(LUT_DEPTH)) n_eff = 8'(LUT_DEPTH);
		else n_eff = 8'(bcount_q);
	end
	assign n_last = BP_AW'(n_eff - 8'd1);

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign ld_en    = in_acc && (command != CMD_COMPUTE);

	tarm_tables #(
		.MAX_THRUSTERS(MAX_THRUSTERS),
		.LUT_DEPTH    (LUT_DEPTH)
	) u_tables (
		.clk        (clk),
		.ld_en      (ld_en),
		.command    (command),
		.table_row  (table_row),
		.table_col  (table_col),
		.table_value(table_value),
		.mat_addr   (mat_addr_q),
		.mat_rd     (mat_rd),
		.bp_addr    (bp_addr),
		.tbp_rd     (tbp_rd),
		.rbp_rd     (rbp_rd),
		.mod_sel    (t_q),
		.mod_val    (mod_val),
		.sat_lim    (sat_lim)
	);

	assign in_vec[0] = force_x;
	assign in_vec[1] = force_y;
	assign in_vec[2] = force_z;
	assign in_vec[3] = moment_x;
	assign in_vec[4] = moment_y;
	assign in_vec[5] = moment_z;

	// breakpoint read address
	always_comb begin
		unique case (state_q)
			ST_LUT_CHK0: bp_addr = n_last;
			ST_LUT_CHKN: bp_addr = BP_AW'(1);
			ST_LUT_SRCH: bp_addr = i_q + 1'b1;
			default:     bp_addr = '0;
		endcase
	end

	// comparisons and segment terms
	assign tbp_ext  = THR_W'(tbp_rd);
	assign f_gt     = thr_q > tbp_ext;
	assign f_lt     = thr_q < tbp_ext;
	assign i_last   = (i_q == n_last);
	assign df       = DF_W'(prev_bp_q) - DF_W'(lo_bp_q);
	assign df_zero  = (df == '0);
	assign dr       = (RPM_W+1)'(prev_rpm_q) - (RPM_W+1)'(lo_rpm_q);
	assign fd_full  = thr_q - THR_W'(lo_bp_q);
	assign dot_last = (k_q == 3'(AXES - 1));
	assign t_last   = (5'(t_q) == tc_eff - 5'd1);
	assign emit_go  = !out_valid || out_ready;
	assign sum_w    = acc_q + prod_q;
	assign div_sub  = ACC_W'(dsh_q);
	assign div_ge   = acc_q >= div_sub;

	// shared multiplier operands
	always_comb begin
		unique case (state_q)
			ST_DOT_MUL: begin
				mul_a = MUL_W'(mat_rd);
				mul_b = MUL_W'(vec_q[k_q]);
			end
			ST_IP_M1: begin
				mul_a = MUL_W'(lo_rpm_q);
				mul_b = MUL_W'(df);
			end
			ST_IP_M2: begin
				mul_a = fd_full[MUL_W-1:0];
				mul_b = MUL_W'(dr);
			end
			default: begin
				mul_a = MUL_W'(lut_q);
				mul_b = MUL_W'(mod_val);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && command == CMD_COMPUTE)
					state_d = active_q ? ST_DOT_RD : ST_EMIT;
			end
			ST_DOT_RD:   state_d = ST_DOT_MUL;
			ST_DOT_MUL:  state_d = ST_DOT_ACC;
			ST_DOT_ACC:  state_d = dot_last ? ST_LUT_RD0 : ST_DOT_RD;
			ST_LUT_RD0:  state_d = ST_LUT_CHK0;
			ST_LUT_CHK0: state_d = f_gt ? ST_MOD_MUL : ST_LUT_CHKN;
			ST_LUT_CHKN: state_d = f_lt ? ST_MOD_MUL : ST_LUT_SRCH;
			ST_LUT_SRCH: begin
				if (f_gt || i_last) state_d = ST_IP_M1;
			end
			ST_IP_M1:    state_d = df_zero ? ST_MOD_MUL : ST_IP_M2;
			ST_IP_M2:    state_d = ST_IP_ADD;
			ST_IP_ADD:   state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) state_d = ST_DIV_END;
			end
			ST_DIV_END:  state_d = ST_MOD_MUL;
			ST_MOD_MUL:  state_d = ST_MOD_SAT;
			ST_MOD_SAT:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_go) state_d = t_last ? ST_IDLE : (active_q ? ST_DOT_RD : ST_EMIT);
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				t_q        <= '0;
				k_q        <= '0;
				mat_addr_q <= '0;
				rpm_q      <= '0;
				for (int a = 0; a < AXES; a++) begin
					if (in_vec[a] > sat_lim[a]) vec_q[a] <= sat_lim[a];
					else if (in_vec[a] < sat_lim[AXES + a]) vec_q[a] <= sat_lim[AXES + a];
					else vec_q[a] <= in_vec[a];
				end
			end
			ST_DOT_ACC: begin
				acc_q      <= ((k_q == 3'd0) ? '0 : acc_q) + prod_q;
				mat_addr_q <= mat_addr_q + 1'b1;
				k_q        <= dot_last ? 3'd0 : k_q + 3'd1;
			end
			ST_LUT_RD0: thr_q <= acc_q[ACC_W-1:FRAC_BITS];
			ST_LUT_CHK0: begin
				lut_q      <= rbp_rd;
				prev_bp_q  <= tbp_rd;
				prev_rpm_q <= rbp_rd;
			end
			ST_LUT_CHKN: begin
				lut_q <= rbp_rd;
				i_q   <= BP_AW'(1);
			end
			ST_LUT_SRCH: begin
				if (f_gt || i_last) begin
					lo_bp_q  <= tbp_rd;
					lo_rpm_q <= rbp_rd;
				end else begin
					prev_bp_q  <= tbp_rd;
					prev_rpm_q <= rbp_rd;
					i_q        <= i_q + 1'b1;
				end
			end
			ST_IP_M1: lut_q <= lo_rpm_q;
			ST_IP_M2: acc_q <= prod_q;
			ST_IP_ADD: begin
				// remainder magnitude, divisor aligned to top quotient bit
				neg_q <= sum_w[ACC_W-1];
				acc_q <= sum_w[ACC_W-1] ? -sum_w : sum_w;
				dsh_q <= {df[DF_W-1:0], {(Q_W-1){1'b0}}};
				q_q   <= '0;
				cnt_q <= CNT_W'(Q_W - 1);
			end
			ST_DIV: begin
				if (div_ge) acc_q <= acc_q - div_sub;
				q_q   <= {q_q[Q_W-2:0], div_ge};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			ST_DIV_END: lut_q <= neg_q ? RPM_W'(-q_q) : RPM_W'(q_q);
			ST_MOD_SAT: begin
				if (prod_q > ACC_W'(32767)) rpm_q <= 16'sh7fff;
				else if (prod_q < -ACC_W'(32768)) rpm_q <= -16'sh8000;
				else rpm_q <= prod_q[RPM_W-1:0];
			end
			ST_EMIT: begin
				if (emit_go) begin
					t_q   <= t_q + 1'b1;
					rpm_q <= '0;
				end
			end
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (state_q == ST_EMIT && emit_go) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && emit_go) begin
			thruster_index <= 3'(t_q);
			rpm_value      <= rpm_q;
			last_thruster  <= t_last;
		end
	end

	// search index stays inside the table in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LUT_SRCH) |-> (i_q <= n_last))
		else $error("breakpoint search ran past last entry");

	// divisor never zero while dividing
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dsh_q != '0))
		else $error("divide with zero divisor");

	// interpolated quotient stays within rpm range
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_END) |-> (q_q <= Q_W'(32768)))
		else $error("interpolation quotient out of range");

	// a word is only loaded into the output register from the emit step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_EMIT))
		else $error("output word raised outside emit");

endmodule
`default_nettype wire
